// ===== rtl/qf2s_pkg.sv =====
// Package with the item types and codes of the two-stack queue.
`default_nettype none

package qf2s_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 9;

  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_DEQUEUE = 2'd1;
  localparam logic [1:0] ACT_PEEK    = 2'd2;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] value_out;
    logic [COUNT_W-1:0]       element_count;
    logic                     is_empty;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/qf2s_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module qf2s_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/queue_from_two_stacks_top.sv =====
// Two-stack FIFO queue: the input stack takes enqueues, the output stack serves the front.
//
// Usage: each input item (in_valid/in_ready) carries an action and a value. Enqueue
// pushes the value onto the input stack; dequeue and peek pop or read the output
// stack. Exactly one result item leaves on out_valid/out_ready per input item, in order.
// Items are handled one at a time by a small sequencer around two RAMs with
// registered read ports.
// Steps per item, from accept to result in the output register:
//   enqueue or unused code, and any item that finds the queue empty: accept, execute
//   dequeue or peek with a filled output stack: accept, execute, one RAM read
//   dequeue or peek with an empty output stack: accept, execute, a transfer that
//   moves every element of the input stack across, one per cycle through the input
//   stack's read port and the output stack's write port, then one RAM read.
// Each element crosses once.
// The result sits in an output register; the next item is taken while it waits.
// If the receiver stalls and a second result is ready, the sequencer holds it
// until the output register frees up, and accepts nothing meanwhile.
// Reset (rst_n low, synchronous) empties both stacks by clearing the fill levels;
// the RAM contents are not cleared and need no clearing pass.
`default_nettype none

module queue_from_two_stacks_top #(
  parameter int STACK_DEPTH = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire qf2s_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output qf2s_pkg::out_item_t       out_item
);

  localparam int AW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FILL_W = $clog2(STACK_DEPTH + 1);
  localparam int CNT_W  = $clog2(2 * STACK_DEPTH + 1);
  localparam int EXT_W  = (CNT_W > qf2s_pkg::COUNT_W) ? CNT_W : qf2s_pkg::COUNT_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_XFER = 5'b00100,
    S_READ = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [1:0]                   act_r, act_nxt;
  logic [qf2s_pkg::DATA_W-1:0]  val_r, val_nxt;
  logic [FILL_W-1:0]            in_fill_r, in_fill_nxt;
  logic [FILL_W-1:0]            out_fill_r, out_fill_nxt;
  logic [CNT_W-1:0]             total_r, total_nxt;
  logic                         pend_r, pend_nxt;
  qf2s_pkg::out_item_t          res_r, res_nxt;
  logic                         out_valid_r, out_valid_nxt;
  qf2s_pkg::out_item_t          out_item_r, out_item_nxt;

  logic                         finish;
  logic [1:0]                   fin_status;
  logic [qf2s_pkg::DATA_W-1:0]  fin_value;
  logic [EXT_W-1:0]             total_ext;
  logic                         load_ok;

  logic [FILL_W-1:0]            in_top, out_top;

  logic                         iw_en, ir_en, ow_en, or_en;
  logic [AW-1:0]                iw_addr, ir_addr, ow_addr, or_addr;
  logic [qf2s_pkg::DATA_W-1:0]  ir_data, or_data;

  assign in_top  = in_fill_r - FILL_W'(1);
  assign out_top = out_fill_r - FILL_W'(1);
  assign load_ok = !out_valid_r || out_ready;

  qf2s_ram #(.WIDTH(qf2s_pkg::DATA_W), .DEPTH(STACK_DEPTH)) u_in_stack (
    .clk     (clk),
    .wr_en   (iw_en),
    .wr_addr (iw_addr),
    .wr_data (val_r),
    .rd_en   (ir_en),
    .rd_addr (ir_addr),
    .rd_data (ir_data)
  );

  qf2s_ram #(.WIDTH(qf2s_pkg::DATA_W), .DEPTH(STACK_DEPTH)) u_out_stack (
    .clk     (clk),
    .wr_en   (ow_en),
    .wr_addr (ow_addr),
    .wr_data (ir_data),
    .rd_en   (or_en),
    .rd_addr (or_addr),
    .rd_data (or_data)
  );

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    val_nxt      = val_r;
    in_fill_nxt  = in_fill_r;
    out_fill_nxt = out_fill_r;
    total_nxt    = total_r;
    pend_nxt     = pend_r;
    in_ready     = 1'b0;
    finish       = 1'b0;
    fin_status   = qf2s_pkg::STATUS_DONE;
    fin_value    = '0;
    iw_en        = 1'b0;
    iw_addr      = in_fill_r[AW-1:0];
    ir_en        = 1'b0;
    ir_addr      = in_top[AW-1:0];
    ow_en        = 1'b0;
    ow_addr      = out_fill_r[AW-1:0];
    or_en        = 1'b0;
    or_addr      = out_top[AW-1:0];

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          act_nxt   = in_item.action;
          val_nxt   = in_item.value_in;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (act_r)
          qf2s_pkg::ACT_ENQUEUE: begin
            finish = 1'b1;
            if (in_fill_r == FILL_W'(STACK_DEPTH)) begin
              fin_status = qf2s_pkg::STATUS_FULL;
            end else begin
              iw_en       = 1'b1;
              in_fill_nxt = in_fill_r + FILL_W'(1);
              total_nxt   = total_r + CNT_W'(1);
            end
          end
          qf2s_pkg::ACT_DEQUEUE, qf2s_pkg::ACT_PEEK: begin
            if (in_fill_r == '0 && out_fill_r == '0) begin
              finish     = 1'b1;
              fin_status = qf2s_pkg::STATUS_EMPTY;
            end else if (out_fill_r == '0) begin
              pend_nxt  = 1'b0;
              state_nxt = S_XFER;
            end else begin
              or_en     = 1'b1;
              state_nxt = S_READ;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      S_XFER: begin
        // Each write into the output stack follows in the next cycle the read from
        // the input stack that fed it; pend_r marks read data waiting to be written.
        if (in_fill_r != '0) begin
          ir_en       = 1'b1;
          in_fill_nxt = in_top;
        end
        if (pend_r) begin
          ow_en        = 1'b1;
          out_fill_nxt = out_fill_r + FILL_W'(1);
        end
        pend_nxt = (in_fill_r != '0);
        if (in_fill_r == '0 && !pend_r) begin
          or_en     = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        finish    = 1'b1;
        fin_value = or_data;
        if (act_r == qf2s_pkg::ACT_DEQUEUE) begin
          out_fill_nxt = out_top;
          total_nxt    = total_r - CNT_W'(1);
        end
      end
      S_HOLD: begin
        if (load_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt = load_ok ? S_IDLE : S_HOLD;
    end
  end

  assign total_ext = EXT_W'(total_nxt);

  always_comb begin
    res_nxt = res_r;
    if (finish) begin
      res_nxt.status        = fin_status;
      res_nxt.value_out     = $signed(fin_value);
      res_nxt.element_count = total_ext[qf2s_pkg::COUNT_W-1:0];
      res_nxt.is_empty      = (total_nxt == '0);
    end

    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if ((finish || state_r == S_HOLD) && load_ok) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_fill_r   <= '0;
      out_fill_r  <= '0;
      total_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_fill_r   <= in_fill_nxt;
      out_fill_r  <= out_fill_nxt;
      total_r     <= total_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    val_r      <= val_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== rtl/qf2s_checker.sv =====
// Port-level checker for the two-stack queue, bound to the top level.
`default_nettype none

module qf2s_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire qf2s_pkg::out_item_t out_item
);

  // A stalled result must hold its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // An empty queue reports a zero count.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.is_empty |-> out_item.element_count == '0)
    else $error("empty flag with nonzero count");

  // Only an item with done status may carry a value; a failed item carries zero.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != qf2s_pkg::STATUS_DONE |-> out_item.value_out == '0)
    else $error("value on a failed item");

  // An empty status only comes from a queue that stays empty.
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == qf2s_pkg::STATUS_EMPTY |-> out_item.is_empty)
    else $error("empty status on a filled queue");

  // Coming out of reset, no result is shown.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind queue_from_two_stacks_top qf2s_checker u_qf2s_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire
